// ----- sv/qcb_pkg.sv -----
package qcb_pkg;

    localparam logic [1:0] ST_EMITTED = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_FADED   = 2'd2;
    localparam logic [1:0] ST_CLIPPED = 2'd3;

    localparam logic [2:0] REG_MODE_FLAGS  = 3'd0;
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd1;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd3;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd4;
    localparam logic [2:0] REG_ANIM_DX     = 3'd5;
    localparam logic [2:0] REG_ANIM_DY     = 3'd6;
    localparam logic [2:0] REG_ANIM_ALPHA  = 3'd7;

    localparam logic [16:0] FADE_LIMIT = 17'd195;
    localparam logic [14:0] ONE_PIXEL  = 15'd16;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 184;

    // one classified quad, handed from front to back
    typedef struct packed {
        logic [1:0]         status;
        logic               need_div;
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        w;
        logic [15:0]        h;
        logic [15:0]        u0;
        logic [15:0]        v0;
        logic [15:0]        u1;
        logic [15:0]        v1;
        logic [31:0]        rgba;
        logic [15:0]        base;
        logic               new_run;
        logic signed [16:0] su;
        logic signed [16:0] sv;
        logic [16:0]        cut_l;
        logic [16:0]        cut_r;
        logic [16:0]        cut_t;
        logic [16:0]        cut_b;
        logic [14:0]        dw;
        logic [14:0]        dh;
    } qcb_job_t;

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'h7fff;
        end else if (v < -18'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

endpackage

// ----- sv/qcb_front.sv -----
module qcb_front import qcb_pkg::*; #(
    parameter int VERTEX_CAPACITY = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_addr,
    input  logic [15:0]           cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  push,
    output qcb_job_t              job,
    input  logic                  q_ready
);

    logic [1:0]  mode_reg;
    logic [15:0] clip_l_reg, clip_t_reg, clip_r_reg, clip_b_reg, dx_reg, dy_reg;
    logic [8:0]  alpha_reg;
    logic [16:0] vc_reg, vc_next;
    logic [6:0]  run_tex_reg, run_tex_next;
    logic        run_mode_reg, run_mode_next, run_open_reg, run_open_next;

    logic signed [15:0] px, py, sw, sh;
    logic [15:0] u0, v0, u1, v1;
    logic [31:0] rgba;
    logic [6:0]  tex;
    logic        smode;
    logic [16:0] vc_eff;
    logic        open_eff, full, fade, away, cut_any;
    logic [16:0] p;
    logic [8:0]  a_rnd;
    logic [7:0]  a_new;
    logic signed [15:0] px1, py1;
    logic signed [16:0] x1, y1, cx0, cy0, cx1, cy1;
    logic signed [17:0] dxw, dyh, lc, rc, tc, bc;

    assign px    = s_tdata[15:0];
    assign py    = s_tdata[31:16];
    assign sw    = s_tdata[47:32];
    assign sh    = s_tdata[63:48];
    assign u0    = s_tdata[79:64];
    assign v0    = s_tdata[95:80];
    assign u1    = s_tdata[111:96];
    assign v1    = s_tdata[127:112];
    assign rgba  = s_tdata[159:128];
    assign tex   = s_tdata[166:160];
    assign smode = s_tdata[167];

    assign s_tready = q_ready;
    assign push     = s_tvalid && q_ready;

    always_comb begin
        vc_eff   = s_tuser ? 17'd0 : vc_reg;
        open_eff = s_tuser ? 1'b0 : run_open_reg;
        full     = ({1'b0, vc_eff} + 18'd4) > 18'(VERTEX_CAPACITY);

        p     = 17'(rgba[7:0] * alpha_reg);
        fade  = mode_reg[1] && (p <= FADE_LIMIT);
        a_rnd = 9'((p + 17'd128) >> 8);
        a_new = a_rnd[8] ? 8'hff : a_rnd[7:0];

        px1 = mode_reg[1] ? sat16(18'(px) + 18'($signed(dx_reg))) : px;
        py1 = mode_reg[1] ? sat16(18'(py) + 18'($signed(dy_reg))) : py;

        x1  = 17'(px1) + 17'(sw);
        y1  = 17'(py1) + 17'(sh);
        cx0 = (17'(px1) > 17'($signed(clip_l_reg))) ? 17'(px1) : 17'($signed(clip_l_reg));
        cy0 = (17'(py1) > 17'($signed(clip_t_reg))) ? 17'(py1) : 17'($signed(clip_t_reg));
        cx1 = (x1 < 17'($signed(clip_r_reg))) ? x1 : 17'($signed(clip_r_reg));
        cy1 = (y1 < 17'($signed(clip_b_reg))) ? y1 : 17'($signed(clip_b_reg));
        away    = mode_reg[0] && (cx0 >= cx1 || cy0 >= cy1);
        cut_any = mode_reg[0] && (cx0 != 17'(px1) || cy0 != 17'(py1) || cx1 != x1 || cy1 != y1);
        dxw = 18'(cx1) - 18'(cx0);
        dyh = 18'(cy1) - 18'(cy0);
        lc  = 18'(cx0) - 18'(px1);
        rc  = 18'(x1) - 18'(cx1);
        tc  = 18'(cy0) - 18'(py1);
        bc  = 18'(y1) - 18'(cy1);

        job = '0;
        if (full) begin
            job.status = ST_FULL;
        end else if (fade) begin
            job.status = ST_FADED;
        end else if (away) begin
            job.status = ST_CLIPPED;
        end else begin
            job.status   = ST_EMITTED;
            job.need_div = cut_any;
            job.x        = cut_any ? cx0[15:0] : px1;
            job.y        = cut_any ? cy0[15:0] : py1;
            job.w        = cut_any ? sat16(dxw) : sw;
            job.h        = cut_any ? sat16(dyh) : sh;
            job.u0       = u0;
            job.v0       = v0;
            job.u1       = u1;
            job.v1       = v1;
            job.rgba     = mode_reg[1] ? {rgba[31:8], a_new} : rgba;
            job.base     = vc_eff[15:0];
            job.new_run  = !open_eff || run_tex_reg != tex || run_mode_reg != smode;
            job.su       = $signed({1'b0, u1}) - $signed({1'b0, u0});
            job.sv       = $signed({1'b0, v1}) - $signed({1'b0, v0});
            job.cut_l    = lc[16:0];
            job.cut_r    = rc[16:0];
            job.cut_t    = tc[16:0];
            job.cut_b    = bc[16:0];
            job.dw       = (sw > 16'sd0) ? sw[14:0] : ONE_PIXEL;
            job.dh       = (sh > 16'sd0) ? sh[14:0] : ONE_PIXEL;
        end

        vc_next       = vc_reg;
        run_open_next = run_open_reg;
        run_tex_next  = run_tex_reg;
        run_mode_next = run_mode_reg;
        if (push) begin
            vc_next       = vc_eff;
            run_open_next = open_eff;
            if (job.status == ST_EMITTED) begin
                vc_next       = vc_eff + 17'd4;
                run_open_next = 1'b1;
                run_tex_next  = tex;
                run_mode_next = smode;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= '0;
            clip_l_reg   <= '0;
            clip_t_reg   <= '0;
            clip_r_reg   <= 16'h7fff;
            clip_b_reg   <= 16'h7fff;
            dx_reg       <= '0;
            dy_reg       <= '0;
            alpha_reg    <= 9'd256;
            vc_reg       <= '0;
            run_tex_reg  <= '0;
            run_mode_reg <= 1'b0;
            run_open_reg <= 1'b0;
        end else begin
            vc_reg       <= vc_next;
            run_tex_reg  <= run_tex_next;
            run_mode_reg <= run_mode_next;
            run_open_reg <= run_open_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_MODE_FLAGS:  mode_reg   <= cfg_wdata[1:0];
                    REG_CLIP_LEFT:   clip_l_reg <= cfg_wdata;
                    REG_CLIP_TOP:    clip_t_reg <= cfg_wdata;
                    REG_CLIP_RIGHT:  clip_r_reg <= cfg_wdata;
                    REG_CLIP_BOTTOM: clip_b_reg <= cfg_wdata;
                    REG_ANIM_DX:     dx_reg     <= cfg_wdata;
                    REG_ANIM_DY:     dy_reg     <= cfg_wdata;
                    REG_ANIM_ALPHA:  alpha_reg  <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- sv/qcb_queue.sv -----
module qcb_queue import qcb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  qcb_job_t push_job,
    output logic     q_ready,
    input  logic     pop,
    output logic     q_valid,
    output qcb_job_t pop_job
);

    qcb_job_t    mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign q_ready = count_reg != 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- sv/qcb_back.sv -----
module qcb_back import qcb_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  qcb_job_t               pop_job,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic [1:0]             m_tuser
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;

    logic [2:0]  state_reg;
    qcb_job_t    job_reg;
    logic [1:0]  idx_reg;
    logic signed [34:0] prod_reg;
    logic [33:0] quo_reg;
    logic [14:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [15:0] nuv_reg [4];
    logic        out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic        out_free;
    logic        out_load;
    logic signed [16:0] span;
    logic [16:0] cut;
    logic [14:0] dsr;
    logic [15:0] orig;
    logic [15:0] trial;
    logic        bit_q;
    logic signed [35:0] qs, val;
    logic [15:0] clamped;

    function automatic logic [OUT_DATA_W-1:0] pack(input qcb_job_t j, input logic [15:0] u0,
                                                   input logic [15:0] v0, input logic [15:0] u1,
                                                   input logic [15:0] v1);
        return {7'd0, j.new_run, j.base, j.rgba, v1, u1, v0, u0, j.h, j.w, j.y, j.x};
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == S_IDLE) && q_valid && out_free;
    // output register takes a new item this cycle
    assign out_load = (pop && !pop_job.need_div) ||
                      (state_reg == S_APPLY && idx_reg == 2'd3);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        span  = idx_reg[1] ? job_reg.sv : job_reg.su;
        dsr   = idx_reg[1] ? job_reg.dh : job_reg.dw;
        case (idx_reg)
            2'd0:    begin cut = job_reg.cut_l; orig = job_reg.u0; end
            2'd1:    begin cut = job_reg.cut_r; orig = job_reg.u1; end
            2'd2:    begin cut = job_reg.cut_t; orig = job_reg.v0; end
            default: begin cut = job_reg.cut_b; orig = job_reg.v1; end
        endcase
        trial = {rem_reg, quo_reg[33]};
        bit_q = trial >= {1'b0, dsr};
        qs    = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        // left and top cuts move the edge forward, right and bottom back
        val   = idx_reg[0] ? $signed({20'd0, orig}) - qs : $signed({20'd0, orig}) + qs;
        if (val < 36'sd0) begin
            clamped = 16'd0;
        end else if (val > 36'sd65535) begin
            clamped = 16'hffff;
        end else begin
            clamped = val[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            if (m_tready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        if (pop_job.need_div) begin
                            job_reg   <= pop_job;
                            idx_reg   <= '0;
                            state_reg <= S_MUL;
                        end else begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= pack(pop_job, pop_job.u0, pop_job.v0,
                                                  pop_job.u1, pop_job.v1);
                            out_user_reg  <= pop_job.status;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg  <= 35'(span) * $signed({18'd0, cut});
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    neg_reg   <= prod_reg[34];
                    quo_reg   <= prod_reg[34] ? 34'(-prod_reg) : prod_reg[33:0];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg <= bit_q ? 15'(trial - {1'b0, dsr}) : trial[14:0];
                    quo_reg <= {quo_reg[32:0], bit_q};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd33) begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    nuv_reg[idx_reg] <= clamped;
                    idx_reg          <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= pack(job_reg, nuv_reg[0], nuv_reg[2],
                                              nuv_reg[1], clamped);
                        out_user_reg  <= job_reg.status;
                        state_reg     <= S_IDLE;
                    end else begin
                        state_reg <= S_MUL;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/quad_clip_and_batch.sv -----
// quad batcher with scissor clip and uv rescale
//
// s_ channel: one quad per item. s_tuser is frame_start, which clears the vertex
// count and run tracking before the quad. m_ channel: one result per item, status
// in m_tuser, rectangle, uvs, color, base vertex and new-run flag in m_tdata.
// cfg_wr_en/cfg_addr/cfg_wdata write one register per cycle; the user must write
// only while idle, which the block itself does not enforce. The front classifies
// a quad in the cycle it is accepted (store-full, fade, offset, clip test, vertex
// and run bookkeeping) and pushes it into a two-entry queue. The back forms the
// result: a quad that is not cut leaves in the cycle after the back pops it; a cut
// quad passes the single shared multiplier and 34-step radix-2 divider once for
// each of its four uvs, through the multiply, prepare, divide and apply states.
// The output register holds a result while m_tready is low; the queue keeps
// accepting until it holds two items, then s_tready drops.
// Reset is synchronous on aresetn: registers take their defaults, counts clear,
// queue and output empty.
module quad_clip_and_batch import qcb_pkg::*; #(
    parameter int VERTEX_CAPACITY = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_addr,
    input  logic [15:0]           cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x, pos_y, size_x, size_y, uv_u0, uv_v0, uv_u1, uv_v1, rgba, texture_id,
    // sample_mode
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // frame_start
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_w, out_h, out_u0, out_v0, out_u1, out_v1, out_rgba,
    // base_vertex, new_run, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]            m_tuser
);

    logic     push, q_ready, q_valid, pop;
    qcb_job_t push_job, pop_job;

    qcb_front #(.VERTEX_CAPACITY(VERTEX_CAPACITY)) u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .push, .job(push_job), .q_ready
    );

    qcb_queue u_queue (
        .aclk, .aresetn, .push, .push_job, .q_ready, .pop, .q_valid, .pop_job
    );

    qcb_back u_back (
        .aclk, .aresetn, .q_valid, .pop_job, .pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_EMITTED |-> m_tdata == '0)
        else $error("rejected quad carries payload");

    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid && s_tready)
        else $error("not empty after reset");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid && (!m_tvalid || m_tready))
        else $error("back took item it could not hold");

endmodule

// ----- tb/sv/quad_clip_and_batch_test.sv -----
`timescale 1ns / 1ps

module quad_clip_and_batch_test;
    import qcb_pkg::*;

    localparam int CAPACITY = 65536;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic               frame_start;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_x;
        logic signed [15:0] size_y;
        logic [15:0]        u0;
        logic [15:0]        v0;
        logic [15:0]        u1;
        logic [15:0]        v1;
        logic [31:0]        rgba;
        logic [6:0]         tex;
        logic               smode;
    } quad_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] u0;
        logic [15:0] v0;
        logic [15:0] u1;
        logic [15:0] v1;
        logic [31:0] rgba;
        logic [15:0] base;
        logic        new_run;
    } batch_out_t;

    // directed row: quad plus an optional hand-typed expectation
    typedef struct {
        quad_t      q;
        bit         typed;
        batch_out_t want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    always #10 aclk = ~aclk;

    quad_clip_and_batch u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // predictor copy of registers and state
    logic [1:0]  mode_r;
    logic signed [15:0] clip_l, clip_t, clip_r, clip_b, off_dx, off_dy;
    logic [8:0]  fade_scale;
    logic [16:0] vert_count;
    logic [6:0]  cur_tex;
    logic        cur_mode;
    logic        run_live;

    batch_out_t expected_batch[$];
    int mismatches = 0;
    int unexpected = 0;
    int results_seen = 0;
    int accepted_items = 0;
    int clip_cuts = 0;
    int idle_pct = 21;
    bit timed_out = 1'b0;
    int quiet_cycles = 0;

    function automatic logic [15:0] clamp_uv(input longint v);
        if (v < 0) return 16'h0000;
        if (v > 65535) return 16'hffff;
        return v[15:0];
    endfunction

    function automatic logic [15:0] sat_q(input longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic batch_out_t predict_quad(input quad_t q);
        batch_out_t r;
        longint px, py, sw, sh, x1, y1, cx0, cy0, cx1, cy1, su, sv, dw, dh;
        logic [15:0] u0, v0, u1, v1, ow, oh;
        logic [31:0] col;
        int unsigned p, a;
        r = '0;
        px = q.pos_x; py = q.pos_y; sw = q.size_x; sh = q.size_y;
        u0 = q.u0; v0 = q.v0; u1 = q.u1; v1 = q.v1; col = q.rgba;
        ow = q.size_x; oh = q.size_y;
        if (q.frame_start) begin
            vert_count = '0;
            run_live = 1'b0;
        end
        if (int'(vert_count) + 4 > CAPACITY) begin
            r.status = ST_FULL;
            return r;
        end
        if (mode_r[1]) begin
            p = col[7:0] * fade_scale;
            px = $signed(sat_q(q.pos_x + longint'(off_dx)));
            py = $signed(sat_q(q.pos_y + longint'(off_dy)));
            if (p <= 195) begin
                r.status = ST_FADED;
                return r;
            end
            a = (p + 128) >> 8;
            if (a > 255) a = 255;
            col[7:0] = a[7:0];
        end
        if (mode_r[0]) begin
            x1 = px + sw; y1 = py + sh;
            cx0 = px > clip_l ? px : longint'(clip_l);
            cy0 = py > clip_t ? py : longint'(clip_t);
            cx1 = x1 < clip_r ? x1 : longint'(clip_r);
            cy1 = y1 < clip_b ? y1 : longint'(clip_b);
            if (cx0 >= cx1 || cy0 >= cy1) begin
                r.status = ST_CLIPPED;
                return r;
            end
            if (cx0 != px || cy0 != py || cx1 != x1 || cy1 != y1) begin
                su = longint'(q.u1) - longint'(q.u0);
                sv = longint'(q.v1) - longint'(q.v0);
                dw = sw > 0 ? sw : 16;
                dh = sh > 0 ? sh : 16;
                u0 = clamp_uv(longint'(q.u0) + su * (cx0 - px) / dw);
                v0 = clamp_uv(longint'(q.v0) + sv * (cy0 - py) / dh);
                u1 = clamp_uv(longint'(q.u1) - su * (x1 - cx1) / dw);
                v1 = clamp_uv(longint'(q.v1) - sv * (y1 - cy1) / dh);
                px = cx0; py = cy0;
                ow = sat_q(cx1 - cx0);
                oh = sat_q(cy1 - cy0);
                clip_cuts++;
            end
        end
        r.new_run = !run_live || cur_tex != q.tex || cur_mode != q.smode;
        run_live = 1'b1;
        cur_tex = q.tex;
        cur_mode = q.smode;
        r.status = ST_EMITTED;
        r.x = px[15:0]; r.y = py[15:0]; r.w = ow; r.h = oh;
        r.u0 = u0; r.v0 = v0; r.u1 = u1; r.v1 = v1;
        r.rgba = col;
        r.base = vert_count[15:0];
        vert_count = vert_count + 17'd4;
        return r;
    endfunction

    function automatic quad_t rand_quad(input bit wide);
        quad_t q;
        q.frame_start = ($urandom_range(0, 29) == 0);
        if (wide || $urandom_range(0, 3) == 0) begin
            q.pos_x = $urandom; q.pos_y = $urandom;
            q.size_x = $urandom; q.size_y = $urandom;
        end else begin
            q.pos_x = 16'($urandom_range(0, 8000) - 2000);
            q.pos_y = 16'($urandom_range(0, 8000) - 2000);
            q.size_x = 16'($urandom_range(0, 3000) - 100);
            q.size_y = 16'($urandom_range(0, 3000) - 100);
        end
        q.u0 = $urandom; q.v0 = $urandom; q.u1 = $urandom; q.v1 = $urandom;
        q.rgba = $urandom;
        q.tex = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 2));
        q.smode = ($urandom_range(0, 3) == 0);
        return q;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MODE_FLAGS:  mode_r = val[1:0];
            REG_CLIP_LEFT:   clip_l = val;
            REG_CLIP_TOP:    clip_t = val;
            REG_CLIP_RIGHT:  clip_r = val;
            REG_CLIP_BOTTOM: clip_b = val;
            REG_ANIM_DX:     off_dx = val;
            REG_ANIM_DY:     off_dy = val;
            REG_ANIM_ALPHA:  fade_scale = val[8:0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_batch.size() > 0 && !timed_out) @(posedge aclk);
        // allow the block to settle before register writes
        repeat (200) @(posedge aclk);
    endtask

    // the predictor runs at acceptance so state follows the block in order
    task automatic send_quad(input quad_t q, input bit typed, input batch_out_t want);
        batch_out_t r;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.frame_start;
        s_tdata <= {q.smode, q.tex, q.rgba, q.v1, q.u1, q.v0, q.u0,
                    q.size_y, q.size_x, q.pos_y, q.pos_x};
        @(posedge aclk);
        while (!s_tready && !timed_out) @(posedge aclk);
        r = predict_quad(q);
        if (typed) r = want;
        expected_batch = {expected_batch, r};
        accepted_items++;
    endtask

    task automatic config_all(input logic [1:0] m, input logic [15:0] l, t, rr, b,
                              input logic [15:0] dx, dy, input logic [8:0] al);
        write_reg(REG_MODE_FLAGS, {14'd0, m});
        write_reg(REG_CLIP_LEFT, l);
        write_reg(REG_CLIP_TOP, t);
        write_reg(REG_CLIP_RIGHT, rr);
        write_reg(REG_CLIP_BOTTOM, b);
        write_reg(REG_ANIM_DX, dx);
        write_reg(REG_ANIM_DY, dy);
        write_reg(REG_ANIM_ALPHA, {7'd0, al});
    endtask

    // result side: random stalls, compare against oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                batch_out_t got, want;
                got = '0;
                got.status = m_tuser;
                {got.new_run, got.base, got.rgba, got.v1, got.u1, got.v0, got.u0,
                 got.h, got.w, got.y, got.x} = m_tdata[176:0];
                results_seen++;
                if (expected_batch.size() == 0) begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = expected_batch.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches + unexpected <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            m_tready <= !(idle_pct > 0 && $urandom_range(0, 99) < idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results pending", expected_batch.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    row_t rows[$];

    task automatic add_row(input quad_t q, input bit typed, input batch_out_t want);
        row_t rw;
        rw.q = q; rw.typed = typed; rw.want = want;
        rows = {rows, rw};
    endtask

    initial begin
        quad_t q;
        batch_out_t w, none;
        mode_r = 2'd0; clip_l = '0; clip_t = '0; clip_r = 16'sh7fff; clip_b = 16'sh7fff;
        off_dx = '0; off_dy = '0; fade_scale = 9'd256;
        vert_count = '0; cur_tex = '0; cur_mode = 1'b0; run_live = 1'b0;
        none = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first quad after reset passes unchanged, base 0, new run
        q = '0;
        q.pos_x = 16'sh7fff; q.pos_y = 16'sh8000; q.size_x = 16'sh8000; q.size_y = 16'sh7fff;
        q.u0 = 16'hffff; q.v0 = '0; q.u1 = '0; q.v1 = 16'hffff; q.rgba = 32'hffffffff;
        q.tex = 7'h7f; q.smode = 1'b1;
        w = '0; w.status = ST_EMITTED; w.x = 16'h7fff; w.y = 16'h8000; w.w = 16'h8000;
        w.h = 16'h7fff; w.u0 = 16'hffff; w.v1 = 16'hffff; w.rgba = 32'hffffffff;
        w.new_run = 1'b1;
        add_row(q, 1'b1, w);
        q.frame_start = 1'b0; add_row(q, 1'b0, none);
        q.smode = 1'b0; add_row(q, 1'b0, none);
        q.tex = 7'd64; add_row(q, 1'b0, none);
        q.frame_start = 1'b1; add_row(q, 1'b0, none);
        for (int i = 0; i < rows.size(); i++) send_quad(rows[i].q, rows[i].typed, rows[i].want);
        rows.delete();
        drain_results();

        // fade: zero alpha scale kills every quad; extreme offsets saturate
        config_all(2'd2, 16'd0, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 9'd0);
        q = rand_quad(1'b0); q.frame_start = 1'b0;
        w = '0; w.status = ST_FADED;
        add_row(q, 1'b1, w);
        for (int i = 0; i < rows.size(); i++) send_quad(rows[i].q, rows[i].typed, rows[i].want);
        rows.delete();
        drain_results();
        write_reg(REG_ANIM_ALPHA, 16'h01ff);
        for (int a = 0; a < 6; a++) begin
            q = rand_quad(1'b1);
            q.rgba[7:0] = (a == 0) ? 8'd0 : (a == 1) ? 8'd1 : (a == 2) ? 8'hff : 8'($urandom);
            send_quad(q, 1'b0, none);
        end
        drain_results();
        write_reg(REG_ANIM_ALPHA, 16'd196);
        q.rgba[7:0] = 8'd1; send_quad(q, 1'b0, none);
        drain_results();
        write_reg(REG_ANIM_ALPHA, 16'd0);

        // clip: outside, partial on each edge, non-positive size
        config_all(2'd1, 16'd160, 16'd160, 16'd1600, 16'd1600, 16'd0, 16'd0, 9'd256);
        q = rand_quad(1'b0); q.frame_start = 1'b0;
        q.pos_x = 16'sd2000; q.size_x = 16'sd100;
        w = '0; w.status = ST_CLIPPED;
        add_row(q, 1'b1, w);
        q.pos_x = 16'sd100; q.pos_y = 16'sd100; q.size_x = 16'sd2000; q.size_y = 16'sd2000;
        q.u0 = '0; q.u1 = 16'hffff; q.v0 = 16'hffff; q.v1 = '0;
        add_row(q, 1'b0, none);
        q.size_x = 16'sh8000; add_row(q, 1'b0, none);
        q.pos_x = 16'sd160; q.size_x = 16'sd0; add_row(q, 1'b1, w);
        for (int i = 0; i < rows.size(); i++) send_quad(rows[i].q, rows[i].typed, rows[i].want);
        rows.delete();
        drain_results();

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            logic [15:0] cl, ct;
            cl = 16'($urandom_range(0, 3000) - 1000);
            ct = 16'($urandom_range(0, 3000) - 1000);
            if (ph == 7)
                config_all(2'd3, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                           16'h7fff, 9'd256);
            else
                config_all(ph[1:0], cl, ct, 16'(cl + $urandom_range(0, 6000)),
                           16'(ct + $urandom_range(0, 6000)),
                           16'($urandom_range(0, 800) - 400),
                           16'($urandom_range(0, 800) - 400), 9'($urandom_range(0, 300)));
            idle_pct = (ph == 2) ? 0 : 21;
            for (int i = 0; i < 80; i++) send_quad(rand_quad(ph == 5), 1'b0, none);
            drain_results();
        end

        $display("quads accepted: %0d, results checked: %0d, clip rescales: %0d",
                 accepted_items, results_seen, clip_cuts);
        $display("covered fade, offset saturation, clipping, uv rescale and run tracking");
        if (mismatches == 0 && unexpected == 0 && expected_batch.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("mismatches %0d, unexpected %0d, missing %0d",
                     mismatches, unexpected, expected_batch.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
